// ----- hw/rtl/tcw_pkg.sv -----
package tcw_pkg;

    // Screen geometry
    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELL_COUNT = COLUMNS * ROWS;

    // Widths of internal counters and memory addresses
    localparam int CURSOR_W = $clog2(CELL_COUNT + 1);
    localparam int ADDR_W   = $clog2(CELL_COUNT);
    localparam int COL_W    = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

    // Widths of the item fields
    localparam int OPCODE_W     = 1;
    localparam int CHAR_W       = 8;
    localparam int READ_ADDR_W  = 11;
    localparam int CELL_W       = 16;
    localparam int CURSOR_OUT_W = 11;
    localparam int ATTR_W       = 8;
    localparam int WIDE_W       = READ_ADDR_W + CURSOR_W;

    // Typed geometry constants
    localparam logic [CURSOR_W-1:0] CELLS_C    = CURSOR_W'(CELL_COUNT);
    localparam logic [CURSOR_W-1:0] COLS_C     = CURSOR_W'(COLUMNS);
    localparam logic [CURSOR_W-1:0] LAST_ROW_C = CURSOR_W'(CELL_COUNT - COLUMNS);
    localparam logic [CURSOR_W-1:0] LAST_CELL_C = CURSOR_W'(CELL_COUNT - 1);
    localparam logic [COL_W-1:0]    COL_LAST_C = COL_W'(COLUMNS - 1);
    localparam logic [WIDE_W-1:0]   CELLS_WIDE_C = WIDE_W'(CELL_COUNT);

    // Character and attribute codes
    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;
    localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'h20;
    localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'h07;

    // Opcodes
    localparam logic [OPCODE_W-1:0] OP_PUT  = 1'b0;
    localparam logic [OPCODE_W-1:0] OP_READ = 1'b1;

    // Result load selection
    typedef enum logic [1:0] {
        OUT_NONE,
        OUT_PUT,
        OUT_READ,
        OUT_SCROLL
    } t_out_sel;

    typedef logic [CURSOR_W-1:0] t_cursor;

    // Controller to datapath
    typedef struct packed {
        logic     clear_step;
        logic     put;
        logic     read;
        logic     scroll_step;
        logic     fill_step;
        t_out_sel out_sel;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic need_scroll;
        logic scan_end;
        logic scan_last;
    } t_dp_sts;

    // Low bits of the cursor as carried in a result item
    function automatic logic [CURSOR_OUT_W-1:0] cursor_field(input t_cursor c);
        logic [CURSOR_W+CURSOR_OUT_W-1:0] w;
        w = {{CURSOR_OUT_W{1'b0}}, c};
        return w[CURSOR_OUT_W-1:0];
    endfunction

endpackage

// ----- hw/rtl/tcw_dp.sv -----
module tcw_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  tcw_pkg::t_dp_cmd               i_cmd,
    output tcw_pkg::t_dp_sts               o_sts,
    input  logic [tcw_pkg::CHAR_W-1:0]      i_char_code,
    input  logic [tcw_pkg::READ_ADDR_W-1:0] i_read_address,
    input  logic                           i_cfg_wr_en,
    input  logic [tcw_pkg::ATTR_W-1:0]      i_cfg_wr_data,
    output logic [tcw_pkg::CELL_W-1:0]      o_cell_data,
    output logic [tcw_pkg::CURSOR_OUT_W-1:0] o_cursor,
    output logic                           o_scrolled
);
    import tcw_pkg::*;

    logic [CELL_W-1:0] mem [CELL_COUNT];

    logic [ATTR_W-1:0] r_attr;
    t_cursor           r_cursor, n_cursor;
    logic [COL_W-1:0]  r_col, n_col;
    t_cursor           r_scan, n_scan;
    logic              r_wr_pend;
    logic [ADDR_W-1:0] r_wr_addr;
    logic              r_addr_ok;
    logic [CELL_W-1:0] r_rdata;

    logic [CELL_W-1:0]       r_cell_data;
    logic [CURSOR_OUT_W-1:0] r_cursor_out;
    logic                    r_scrolled;

    logic              is_newline;
    t_cursor           step_cursor;
    logic [COL_W-1:0]  step_col;
    logic [WIDE_W-1:0] rd_wide;
    logic              rd_ok;
    t_cursor           wr_back;
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [CELL_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr;

    // Cursor step for a put
    always_comb begin
        is_newline = (i_char_code == NEWLINE_CODE);
        if (is_newline) begin
            step_cursor = r_cursor + (COLS_C - CURSOR_W'(r_col));
            step_col    = '0;
        end else begin
            step_cursor = r_cursor + t_cursor'(1);
            step_col    = (r_col == COL_LAST_C) ? '0 : r_col + COL_W'(1);
        end
    end

    // Status to the controller
    always_comb begin
        o_sts.need_scroll = (step_cursor >= CELLS_C);
        o_sts.scan_end    = (r_scan == CELLS_C);
        o_sts.scan_last   = (r_scan == LAST_CELL_C);
    end

    // Read address check
    always_comb begin
        rd_wide = {{CURSOR_W{1'b0}}, i_read_address};
        rd_ok   = (rd_wide < CELLS_WIDE_C);
    end

    assign wr_back = r_scan - COLS_C;

    // Write port selection
    always_comb begin
        we    = 1'b0;
        waddr = r_scan[ADDR_W-1:0];
        wdata = '0;
        if (i_cmd.clear_step) begin
            we = 1'b1;
        end else if (i_cmd.put) begin
            we    = !is_newline;
            waddr = r_cursor[ADDR_W-1:0];
            wdata = {r_attr, i_char_code};
        end else if (i_cmd.scroll_step) begin
            we    = r_wr_pend;
            waddr = r_wr_addr;
            wdata = r_rdata;
        end else if (i_cmd.fill_step) begin
            we    = 1'b1;
            wdata = {r_attr, SPACE_CODE};
        end
    end

    // Read port selection
    always_comb begin
        raddr = '0;
        if (i_cmd.read) begin
            raddr = rd_ok ? rd_wide[ADDR_W-1:0] : '0;
        end else if (i_cmd.scroll_step && !o_sts.scan_end) begin
            raddr = r_scan[ADDR_W-1:0];
        end
    end

    // Screen store
    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        r_rdata <= mem[raddr];
    end

    // Cursor, column and scan counter
    always_comb begin
        n_cursor = r_cursor;
        n_col    = r_col;
        n_scan   = r_scan;
        if (i_cmd.clear_step || i_cmd.fill_step) begin
            n_scan = r_scan + t_cursor'(1);
        end else if (i_cmd.put) begin
            if (o_sts.need_scroll) begin
                n_cursor = LAST_ROW_C;
                n_col    = '0;
                n_scan   = COLS_C;
            end else begin
                n_cursor = step_cursor;
                n_col    = step_col;
            end
        end else if (i_cmd.scroll_step) begin
            n_scan = o_sts.scan_end ? LAST_ROW_C : r_scan + t_cursor'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr    <= ATTR_RESET;
            r_cursor  <= '0;
            r_col     <= '0;
            r_scan    <= '0;
            r_wr_pend <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_attr <= i_cfg_wr_data;
            end
            r_cursor  <= n_cursor;
            r_col     <= n_col;
            r_scan    <= n_scan;
            r_wr_pend <= i_cmd.scroll_step && !o_sts.scan_end;
        end
    end

    // Copy destination and read range flag
    always_ff @(posedge i_clk) begin
        r_wr_addr <= wr_back[ADDR_W-1:0];
        if (i_cmd.read) begin
            r_addr_ok <= rd_ok;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.out_sel)
            OUT_PUT: begin
                r_cell_data  <= '0;
                r_cursor_out <= cursor_field(step_cursor);
                r_scrolled   <= 1'b0;
            end
            OUT_READ: begin
                r_cell_data  <= r_addr_ok ? r_rdata : '0;
                r_cursor_out <= cursor_field(r_cursor);
                r_scrolled   <= 1'b0;
            end
            OUT_SCROLL: begin
                r_cell_data  <= '0;
                r_cursor_out <= cursor_field(r_cursor);
                r_scrolled   <= 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign o_cell_data = r_cell_data;
    assign o_cursor    = r_cursor_out;
    assign o_scrolled  = r_scrolled;

endmodule

// ----- hw/rtl/tcw_ctrl.sv -----
module tcw_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [tcw_pkg::OPCODE_W-1:0] i_opcode,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output tcw_pkg::t_dp_cmd             o_cmd,
    input  tcw_pkg::t_dp_sts             i_sts
);
    import tcw_pkg::*;

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_READ   = 3'd2;
    localparam logic [2:0] ST_SCROLL = 3'd3;
    localparam logic [2:0] ST_FILL   = 3'd4;

    logic [2:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       out_free;
    logic       accept;

    // Take an item only when idle and the result register will be empty
    assign out_free   = !r_out_valid || !i_out_stall;
    assign accept     = (r_state == ST_IDLE) && out_free && i_in_valid;
    assign o_in_stall = !((r_state == ST_IDLE) && out_free);

    // Sequence the datapath
    always_comb begin
        n_state = r_state;
        o_cmd   = '{clear_step: 1'b0, put: 1'b0, read: 1'b0, scroll_step: 1'b0,
                    fill_step: 1'b0, out_sel: OUT_NONE};
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clear_step = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    if (i_opcode == OP_READ) begin
                        o_cmd.read = 1'b1;
                        n_state    = ST_READ;
                    end else begin
                        o_cmd.put = 1'b1;
                        if (i_sts.need_scroll) begin
                            n_state = ST_SCROLL;
                        end else begin
                            o_cmd.out_sel = OUT_PUT;
                        end
                    end
                end
            end
            ST_READ: begin
                o_cmd.out_sel = OUT_READ;
                n_state       = ST_IDLE;
            end
            ST_SCROLL: begin
                o_cmd.scroll_step = 1'b1;
                if (i_sts.scan_end) begin
                    n_state = ST_FILL;
                end
            end
            ST_FILL: begin
                o_cmd.fill_step = 1'b1;
                if (i_sts.scan_last) begin
                    o_cmd.out_sel = OUT_SCROLL;
                    n_state       = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    // Result valid: set on load, drop when taken
    always_comb begin
        if (o_cmd.out_sel != OUT_NONE) begin
            n_out_valid = 1'b1;
        end else begin
            n_out_valid = r_out_valid && i_out_stall;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ----- hw/rtl/text_console_writer_top.sv -----
// Channel  | Handshake                 | Payload
// ---------+---------------------------+----------------------------------------
// in       | i_in_valid / o_in_stall   | i_opcode, i_char_code, i_read_address
// out      | o_out_valid / i_out_stall | o_cell_data, o_cursor, o_scrolled
// cfg      | i_cfg_wr_en               | i_cfg_wr_data (attribute)
//
// A put without scroll loads its result from the idle state; a read first passes
// through a read state (registered read of the screen RAM). In a put that scrolls,
// the single RAM port pair copies one cell a cycle, then writes the blank bottom
// row one cell a cycle. After reset the screen RAM is cleared one cell a cycle,
// during which o_in_stall is high; attribute writes are taken at any time.
// A result held in the output register under i_out_stall stalls the next item.
module text_console_writer_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [tcw_pkg::OPCODE_W-1:0]     i_opcode,
    input  logic [tcw_pkg::CHAR_W-1:0]       i_char_code,
    input  logic [tcw_pkg::READ_ADDR_W-1:0]  i_read_address,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [tcw_pkg::CELL_W-1:0]       o_cell_data,
    output logic [tcw_pkg::CURSOR_OUT_W-1:0] o_cursor,
    output logic                             o_scrolled,
    input  logic                             i_cfg_wr_en,
    input  logic [tcw_pkg::ATTR_W-1:0]       i_cfg_wr_data
);
    import tcw_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    // Sequence items, scrolls and the clearing pass
    tcw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_opcode    (i_opcode),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    // Screen RAM, cursor and result payload
    tcw_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_char_code    (i_char_code),
        .i_read_address (i_read_address),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .o_cell_data    (o_cell_data),
        .o_cursor       (o_cursor),
        .o_scrolled     (o_scrolled)
    );

endmodule
